@@ rtl/fbpf_pkg.sv @@
`timescale 1ns / 1ps

package fbpf_pkg;

  // Field widths of the request and response channels.
  localparam int OFFSET_W    = 32;
  localparam int SIZE_W      = 17;
  localparam int COUNT_W     = 11;
  localparam int OUT_IDX_W   = 10;
  localparam int OUT_OFF_W   = 26;
  localparam int CFG_DATA_W  = 17;

  // Widest block index that any supported pool depth needs.
  localparam int IDX_MAX_W   = 16;

  // Pool depth and register reset values.
  localparam int POOL_DEPTH_DEFAULT = 1024;
  localparam logic [SIZE_W-1:0]  BLOCK_SIZE_RESET  = SIZE_W'(64);
  localparam logic [COUNT_W-1:0] BLOCK_COUNT_RESET = COUNT_W'(1024);

  // Legal range of the block size.
  localparam logic [SIZE_W-1:0] BS_MIN = SIZE_W'(8);
  localparam logic [SIZE_W-1:0] BS_MAX = SIZE_W'(65536);

  // Depth of the command queue between front and back.
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  // Request kinds.
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_BLOCK_SIZE  = 1'b0,
    REG_BLOCK_COUNT = 1'b1
  } reg_idx_t;

  // Effective configuration after clamping.
  typedef struct packed {
    logic [SIZE_W-1:0]  eff_size;
    logic [COUNT_W-1:0] eff_count;
  } cfg_t;

  // Classified request handed from front to back.
  typedef struct packed {
    logic                 kind;
    logic                 ignored;
    logic [IDX_MAX_W-1:0] idx;
  } cmd_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_PUSH
  } fr_state_t;

  typedef enum logic [1:0] {
    BK_SWEEP,
    BK_IDLE,
    BK_ALLOC_WAIT
  } bk_state_t;

endpackage

@@ rtl/fbpf_if.sv @@
`timescale 1ns / 1ps

// Request channel: one allocate or free per transaction.
interface fbpf_req_if;
  import fbpf_pkg::*;

  logic                valid;
  logic                ready;
  logic                kind;
  logic [OFFSET_W-1:0] offset;

  modport source (output valid, kind, offset, input ready);
  modport sink   (input valid, kind, offset, output ready);
endinterface

// Response channel: one result per request.
interface fbpf_rsp_if;
  import fbpf_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 granted;
  logic                 exhausted;
  logic [OUT_IDX_W-1:0] block_index;
  logic [OUT_OFF_W-1:0] block_offset;
  logic                 ignored;
  logic [COUNT_W-1:0]   free_blocks;

  modport source (output valid, granted, exhausted, block_index, block_offset, ignored,
                  free_blocks, input ready);
  modport sink   (input valid, granted, exhausted, block_index, block_offset, ignored,
                  free_blocks, output ready);
endinterface

@@ rtl/fbpf_ram.sv @@
`timescale 1ns / 1ps

module fbpf_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/fbpf_cmd_fifo.sv @@
`timescale 1ns / 1ps

module fbpf_cmd_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  fbpf_pkg::cmd_t  push_cmd,
  output logic            full,
  input  logic            pop,
  output fbpf_pkg::cmd_t  pop_cmd,
  output logic            empty
);
  import fbpf_pkg::*;

  cmd_t                  entries [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr;
  logic [CMDQ_PTR_W-1:0] rd_ptr;
  logic [CMDQ_CNT_W-1:0] count;
  logic                  do_push;
  logic                  do_pop;

  assign full    = (count == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = entries[rd_ptr];

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

@@ rtl/fbpf_front.sv @@
`timescale 1ns / 1ps

module fbpf_front (
  input  logic           clk,
  input  logic           rst,
  input  fbpf_pkg::cfg_t cfg,
  input  logic           sweeping,
  fbpf_req_if.sink       req,
  output logic           push,
  output fbpf_pkg::cmd_t push_cmd,
  input  logic           fifo_full
);
  import fbpf_pkg::*;

  localparam int BIT_CNT_W = $clog2(OFFSET_W);

  fr_state_t             state;
  fr_state_t             state_next;
  logic                  kind_q;
  logic [OFFSET_W-1:0]   dq;
  logic [SIZE_W-1:0]     rem;
  logic [SIZE_W-1:0]     divisor;
  logic [BIT_CNT_W-1:0]  bit_cnt;
  logic [SIZE_W:0]       rem_sh;
  logic [SIZE_W:0]       rem_diff;
  logic                  fits;
  logic                  accept;

  assign req.ready = (state == FR_IDLE) && !sweeping;
  assign accept    = req.valid && req.ready;

  // One restoring division step: the quotient shifts into dq as the dividend leaves.
  assign rem_sh   = {rem, dq[OFFSET_W-1]};
  assign rem_diff = rem_sh - {1'b0, divisor};
  assign fits     = (rem_sh >= {1'b0, divisor});

  // Classified command; after the division dq holds the block index.
  assign push              = (state == FR_PUSH) && !fifo_full;
  assign push_cmd.kind     = kind_q;
  assign push_cmd.ignored  = (kind_q == KIND_FREE) && (dq >= OFFSET_W'(cfg.eff_count));
  assign push_cmd.idx      = dq[IDX_MAX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state of the front sequencer.
  always_comb begin
    state_next = state;
    case (state)
      FR_IDLE: begin
        if (accept) begin
          state_next = (req.kind == KIND_FREE) ? FR_DIV : FR_PUSH;
        end
      end
      FR_DIV: begin
        if (bit_cnt == BIT_CNT_W'(OFFSET_W - 1)) begin
          state_next = FR_PUSH;
        end
      end
      FR_PUSH: begin
        if (!fifo_full) begin
          state_next = FR_IDLE;
        end
      end
      default: state_next = FR_IDLE;
    endcase
  end

  // Request capture and divider datapath.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q  <= req.kind;
      dq      <= req.offset;
      rem     <= '0;
      divisor <= cfg.eff_size;
      bit_cnt <= '0;
    end else if (state == FR_DIV) begin
      rem     <= fits ? rem_diff[SIZE_W-1:0] : rem_sh[SIZE_W-1:0];
      dq      <= {dq[OFFSET_W-2:0], fits};
      bit_cnt <= bit_cnt + 1'b1;
    end
  end

endmodule

@@ rtl/fbpf_back.sv @@
`timescale 1ns / 1ps

module fbpf_back #(
  parameter int POOL_DEPTH = fbpf_pkg::POOL_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  fbpf_pkg::cfg_t cfg,
  input  logic           rebuild,
  output logic           sweeping,
  input  fbpf_pkg::cmd_t pop_cmd,
  input  logic           fifo_empty,
  output logic           pop,
  fbpf_rsp_if.source     rsp
);
  import fbpf_pkg::*;

  localparam int IDX_W  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int LINK_W = $clog2(POOL_DEPTH + 1);
  localparam int PROD_W = LINK_W + SIZE_W;

  bk_state_t            state;
  bk_state_t            state_next;
  logic [LINK_W-1:0]    head;
  logic [LINK_W-1:0]    head_next;
  logic                 head_valid;
  logic                 head_valid_next;
  logic [COUNT_W-1:0]   free_total;
  logic [COUNT_W-1:0]   free_total_next;
  logic [LINK_W-1:0]    sweep_cnt;
  logic [LINK_W-1:0]    sweep_cnt_next;
  logic [LINK_W-1:0]    sweep_link;

  logic                 out_valid;
  logic                 out_valid_next;
  logic                 out_granted;
  logic                 out_granted_next;
  logic                 out_exhausted;
  logic                 out_exhausted_next;
  logic [OUT_IDX_W-1:0] out_index;
  logic [OUT_IDX_W-1:0] out_index_next;
  logic [OUT_OFF_W-1:0] out_offset;
  logic [OUT_OFF_W-1:0] out_offset_next;
  logic                 out_ignored;
  logic                 out_ignored_next;
  logic [COUNT_W-1:0]   out_free;
  logic [COUNT_W-1:0]   out_free_next;

  logic                 out_slot_free;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [LINK_W:0]      ram_wdata;
  logic [LINK_W:0]      ram_rdata;
  logic [PROD_W-1:0]    product;

  // Link store: each entry holds {end mark, next index}.
  fbpf_ram #(
    .WIDTH (LINK_W + 1),
    .DEPTH (POOL_DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign sweeping      = (state == BK_SWEEP);
  assign out_slot_free = !out_valid || rsp.ready;
  assign sweep_link    = sweep_cnt + 1'b1;
  assign product       = PROD_W'(head) * PROD_W'(cfg.eff_size);

  assign rsp.valid        = out_valid;
  assign rsp.granted      = out_granted;
  assign rsp.exhausted    = out_exhausted;
  assign rsp.block_index  = out_index;
  assign rsp.block_offset = out_offset;
  assign rsp.ignored      = out_ignored;
  assign rsp.free_blocks  = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  // List sequencer: rebuild sweep, then one command at a time.
  always_comb begin
    state_next         = state;
    head_next          = head;
    head_valid_next    = head_valid;
    free_total_next    = free_total;
    sweep_cnt_next     = sweep_cnt;
    out_valid_next     = out_valid && !rsp.ready;
    out_granted_next   = out_granted;
    out_exhausted_next = out_exhausted;
    out_index_next     = out_index;
    out_offset_next    = out_offset;
    out_ignored_next   = out_ignored;
    out_free_next      = out_free;
    pop                = 1'b0;
    ram_we             = 1'b0;
    ram_waddr          = sweep_cnt[IDX_W-1:0];
    ram_wdata          = {(32'(sweep_link) >= 32'(cfg.eff_count)), sweep_link};

    case (state)
      BK_SWEEP: begin
        ram_we         = 1'b1;
        sweep_cnt_next = sweep_link;
        if (sweep_cnt == LINK_W'(POOL_DEPTH - 1)) begin
          head_next       = '0;
          head_valid_next = 1'b1;
          free_total_next = cfg.eff_count;
          state_next      = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!fifo_empty && out_slot_free) begin
          pop                = 1'b1;
          out_granted_next   = 1'b0;
          out_exhausted_next = 1'b0;
          out_index_next     = '0;
          out_offset_next    = '0;
          out_ignored_next   = 1'b0;
          if (pop_cmd.kind == KIND_ALLOC) begin
            if (head_valid && (32'(head) < POOL_DEPTH)) begin
              // The link of the head is read now and arrives next cycle.
              state_next = BK_ALLOC_WAIT;
            end else begin
              head_valid_next    = 1'b0;
              out_valid_next     = 1'b1;
              out_exhausted_next = 1'b1;
              out_free_next      = free_total;
            end
          end else if (pop_cmd.ignored) begin
            out_valid_next   = 1'b1;
            out_ignored_next = 1'b1;
            out_free_next    = free_total;
          end else begin
            // Push the freed block in front of the current head.
            ram_we          = 1'b1;
            ram_waddr       = pop_cmd.idx[IDX_W-1:0];
            ram_wdata       = {!head_valid, head};
            head_next       = LINK_W'(pop_cmd.idx);
            head_valid_next = 1'b1;
            if (free_total < cfg.eff_count) begin
              free_total_next = free_total + 1'b1;
            end
            out_valid_next = 1'b1;
            out_free_next  = free_total_next;
          end
        end
      end
      BK_ALLOC_WAIT: begin
        head_next       = ram_rdata[LINK_W-1:0];
        head_valid_next = !ram_rdata[LINK_W];
        if (free_total != '0) begin
          free_total_next = free_total - 1'b1;
        end
        out_valid_next   = 1'b1;
        out_granted_next = 1'b1;
        out_index_next   = OUT_IDX_W'(head);
        out_offset_next  = product[OUT_OFF_W-1:0];
        out_free_next    = free_total_next;
        state_next       = BK_IDLE;
      end
      default: begin
        state_next = BK_SWEEP;
      end
    endcase

    // A block count write starts the sweep over.
    if (rebuild) begin
      state_next     = BK_SWEEP;
      sweep_cnt_next = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt  <= '0;
      head_valid <= 1'b0;
      free_total <= '0;
      out_valid  <= 1'b0;
    end else begin
      sweep_cnt  <= sweep_cnt_next;
      head_valid <= head_valid_next;
      free_total <= free_total_next;
      out_valid  <= out_valid_next;
    end
  end

  // List head and response payload.
  always_ff @(posedge clk) begin
    head          <= head_next;
    out_granted   <= out_granted_next;
    out_exhausted <= out_exhausted_next;
    out_index     <= out_index_next;
    out_offset    <= out_offset_next;
    out_ignored   <= out_ignored_next;
    out_free      <= out_free_next;
  end

endmodule

@@ rtl/fixed_block_pool_free_list_unit.sv @@
// Allocate: the front queues the request and can take the next one while the back
// reads the head link and registers the grant. Free: the 32-step radix-2 offset
// divider in the front runs first; no new request is taken until it is done.
// Reset (synchronous, active high) and every block count write run a sweep over
// all POOL_DEPTH entries of the link memory, during which requests are held off.
`timescale 1ns / 1ps

module fixed_block_pool_free_list_unit #(
  parameter int POOL_DEPTH = fbpf_pkg::POOL_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  fbpf_pkg::reg_idx_t              cfg_index,
  input  logic [fbpf_pkg::CFG_DATA_W-1:0] cfg_data,
  fbpf_req_if.sink                        req,
  fbpf_rsp_if.source                      rsp
);
  import fbpf_pkg::*;

  logic [SIZE_W-1:0]  size_cfg;
  logic [COUNT_W-1:0] count_cfg;
  cfg_t               cfg;
  logic               rebuild;
  logic               sweeping;
  logic               push;
  cmd_t               push_cmd;
  logic               fifo_full;
  logic               pop;
  cmd_t               pop_cmd;
  logic               fifo_empty;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      size_cfg  <= BLOCK_SIZE_RESET;
      count_cfg <= BLOCK_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLOCK_SIZE:  size_cfg  <= cfg_data[SIZE_W-1:0];
        REG_BLOCK_COUNT: count_cfg <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign rebuild = cfg_we && (cfg_index == REG_BLOCK_COUNT);

  // Clamp the registers to their usable ranges.
  always_comb begin
    if (size_cfg < BS_MIN) begin
      cfg.eff_size = BS_MIN;
    end else if (size_cfg > BS_MAX) begin
      cfg.eff_size = BS_MAX;
    end else begin
      cfg.eff_size = size_cfg;
    end
    if (count_cfg == '0) begin
      cfg.eff_count = COUNT_W'(1);
    end else if (32'(count_cfg) > POOL_DEPTH) begin
      cfg.eff_count = COUNT_W'(POOL_DEPTH);
    end else begin
      cfg.eff_count = count_cfg;
    end
  end

  fbpf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .sweeping  (sweeping),
    .req       (req),
    .push      (push),
    .push_cmd  (push_cmd),
    .fifo_full (fifo_full)
  );

  fbpf_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (fifo_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (fifo_empty)
  );

  fbpf_back #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .rebuild    (rebuild),
    .sweeping   (sweeping),
    .pop_cmd    (pop_cmd),
    .fifo_empty (fifo_empty),
    .pop        (pop),
    .rsp        (rsp)
  );

  // A response never both grants and reports exhaustion.
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.granted && rsp.exhausted))
    else $error("granted and exhausted both set");

  // The reported free count never exceeds the effective block count.
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.free_blocks <= cfg.eff_count))
    else $error("free count above block count");

  // No request is taken while the link memory is being rebuilt.
  assert property (@(posedge clk) disable iff (rst)
    sweeping |-> !req.ready)
    else $error("request accepted during rebuild sweep");

  // A block count write always starts a rebuild sweep.
  assert property (@(posedge clk) disable iff (rst)
    rebuild |=> sweeping)
    else $error("block count write did not start a sweep");

endmodule
